/* hw/rtl/chunked_memory_quota_tracker_unit_defines.svh */
// assertion macros for the chunked memory quota tracker
// expects clk and arst_n in the scope where a macro is used
`ifndef CHUNKED_MEMORY_QUOTA_TRACKER_UNIT_DEFINES_SVH
`define CHUNKED_MEMORY_QUOTA_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define CMQT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CMQT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/cmqt_pkg.sv */
// shared types and constants for the chunked memory quota tracker
// no dependencies
package cmqt_pkg;

	localparam int BYTE_WIDTH_DEF  = 48;
	localparam int CHUNK_WIDTH_DEF = 31;

	// fixed field widths of the stream words
	localparam int OPCODE_W  = 3;
	localparam int BCOUNT_W  = 48;
	localparam int CNT_W     = 31;
	localparam int DELTA_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int SHIFT_W   = 6;
	localparam int SUM_W     = CNT_W + 1;
	localparam int CFG_IDX_W = 2;

	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 128;

	localparam logic [SHIFT_W-1:0] CHUNK_SHIFT_RST = 6'd20;

	typedef enum logic [OPCODE_W-1:0] {
		OP_RESERVE     = 3'd0,
		OP_RELEASE     = 3'd1,
		OP_WAIVER      = 3'd2,
		OP_RESET_PEAK  = 3'd3,
		OP_RELEASE_ALL = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 2'd0,
		ST_QUERY_LIMIT   = 2'd1,
		ST_SEGMENT_QUOTA = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRACK_EN    = 2'd0,
		CFG_CHUNK_SHIFT = 2'd1,
		CFG_QUERY_LIMIT = 2'd2,
		CFG_SEG_QUOTA   = 2'd3
	} cfg_idx_t;

endpackage

/* hw/rtl/chunked_memory_quota_tracker_unit.sv */
// chunked memory quota tracker, top level
// depends on cmqt_pkg and chunked_memory_quota_tracker_unit_defines.svh

// Tracks the bytes held by one client in chunks of 2^chunk_shift bytes and
// answers reserve, release, waiver, peak-reset and release-all requests with
// a status, the chunk delta, the held and peak chunk counts and the free
// segment quota. Each request word is captured in an input register, the new
// tracker state and the result are formed by one pass of add, shift and
// compare logic, and both are registered once the result register is free or
// being taken, so a word can be taken every cycle while the consumer takes
// each result, and the next word sees the state the previous one left. A held
// result does not block the input register as long as the consumer takes
// it. Configuration writes are always ready and should be made while idle.

`include "chunked_memory_quota_tracker_unit_defines.svh"

module chunked_memory_quota_tracker_unit #(
	parameter int BYTE_WIDTH  = cmqt_pkg::BYTE_WIDTH_DEF,
	parameter int CHUNK_WIDTH = cmqt_pkg::CHUNK_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cmqt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cmqt_pkg::CNT_W-1:0]          cfg_data,
	// request stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// byte_count[47:0], enforce[48], session_other_chunks[79:49],
	// segment_other_chunks[110:80]
	input  logic [cmqt_pkg::IN_DATA_W-1:0]      s_tdata,
	// opcode[2:0]
	input  logic [cmqt_pkg::OPCODE_W-1:0]       s_tuser,
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// status[1:0], chunk_delta[33:2], reserved_chunks[64:34],
	// peak_chunks[95:65], available_segment_chunks[126:96]
	output logic [cmqt_pkg::OUT_DATA_W-1:0]     m_tdata
);

	localparam int BCW = cmqt_pkg::BCOUNT_W;
	localparam int XW  = ((BYTE_WIDTH > BCW) ? BYTE_WIDTH : BCW) + 1;
	localparam int SW  = cmqt_pkg::SUM_W;
	localparam int CW  = cmqt_pkg::CNT_W;
	localparam int DW  = cmqt_pkg::DELTA_W;

	localparam logic [XW-1:0] BYTE_MAX_X =
		{{(XW-BYTE_WIDTH){1'b0}}, {BYTE_WIDTH{1'b1}}};
	localparam logic [CHUNK_WIDTH-1:0] CHUNK_MAX = {CHUNK_WIDTH{1'b1}};

	function automatic logic [CHUNK_WIDTH-1:0] to_chunks(
		input logic [BYTE_WIDTH-1:0]        bytes,
		input logic [cmqt_pkg::SHIFT_W-1:0] sh
	);
		logic [BYTE_WIDTH-1:0] c;
		c = bytes >> sh;
		if (|c[BYTE_WIDTH-1:CHUNK_WIDTH]) begin
			return CHUNK_MAX;
		end
		return c[CHUNK_WIDTH-1:0];
	endfunction

	// configuration
	logic                           track_en_q;
	logic [cmqt_pkg::SHIFT_W-1:0]   chunk_shift_q;
	logic [CW-1:0]                  query_limit_q;
	logic [CW-1:0]                  seg_quota_q;

	// tracker state
	logic [BYTE_WIDTH-1:0]          held_bytes_q;
	logic [CHUNK_WIDTH-1:0]         held_chunks_q;
	logic [CHUNK_WIDTH-1:0]         peak_q;
	logic [CHUNK_WIDTH-1:0]         waiver_q;

	// input register
	logic                           valid_s1;
	cmqt_pkg::op_t                  op_s1;
	logic [BCW-1:0]                 bc_s1;
	logic                           enf_s1;
	logic [CW-1:0]                  sess_s1;
	logic [CW-1:0]                  seg_s1;

	// result register
	logic                           m_valid_q;
	cmqt_pkg::status_t              out_status_q;
	logic [DW-1:0]                  out_delta_q;
	logic [CW-1:0]                  out_reserved_q;
	logic [CW-1:0]                  out_peak_q;
	logic [CW-1:0]                  out_avail_q;

	logic fire;

	// next state and result
	logic [BYTE_WIDTH-1:0]          nxt_bytes;
	logic [CHUNK_WIDTH-1:0]         nxt_chunks;
	logic [CHUNK_WIDTH-1:0]         nxt_peak;
	logic [CHUNK_WIDTH-1:0]         nxt_waiver;
	cmqt_pkg::status_t              res_status;
	logic [DW-1:0]                  res_delta;
	logic [CW-1:0]                  res_avail;

	// datapath pieces
	logic [XW-1:0]                  sum_x;
	logic [BYTE_WIDTH-1:0]          rsv_bytes;
	logic [CHUNK_WIDTH-1:0]         rsv_chunks;
	logic [SW-1:0]                  total;
	logic [SW-1:0]                  newseg;
	logic [SW-1:0]                  lim_w;
	logic [SW-1:0]                  quota_w;
	logic                           q_over;
	logic                           q_fail;
	logic                           s_over;
	logic                           s_fail;
	logic [XW-1:0]                  free_x;
	logic [BYTE_WIDTH-1:0]          rel_bytes;
	logic [CHUNK_WIDTH-1:0]         rel_chunks;
	logic [BCW-1:0]                 wq;
	logic                           wrem;
	logic [BCW:0]                   wq_up;
	logic [CHUNK_WIDTH-1:0]         wq_sat;
	logic [SW-1:0]                  used_seg;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready  = !valid_s1 || fire;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = {1'b0, out_avail_q, out_peak_q, out_reserved_q, out_delta_q,
		out_status_q};

	always_comb begin
		// reserve path
		sum_x      = XW'(held_bytes_q) + XW'(bc_s1);
		rsv_bytes  = (sum_x > BYTE_MAX_X) ? BYTE_MAX_X[BYTE_WIDTH-1:0]
			: sum_x[BYTE_WIDTH-1:0];
		rsv_chunks = to_chunks(rsv_bytes, chunk_shift_q);
		total      = SW'(sess_s1) + SW'(rsv_chunks);
		newseg     = SW'(seg_s1) + SW'(rsv_chunks);
		lim_w      = SW'(query_limit_q) + SW'(waiver_q);
		quota_w    = SW'(seg_quota_q) + SW'(waiver_q);
		q_over     = enf_s1 && (query_limit_q != '0) && (total > SW'(query_limit_q));
		q_fail     = q_over && (total > lim_w);
		s_over     = enf_s1 && (newseg > SW'(seg_quota_q));
		s_fail     = !q_fail && s_over && (newseg > quota_w);

		// release path, never frees more than is held
		free_x     = (XW'(bc_s1) < XW'(held_bytes_q)) ? XW'(bc_s1) : XW'(held_bytes_q);
		rel_bytes  = held_bytes_q - free_x[BYTE_WIDTH-1:0];
		rel_chunks = to_chunks(rel_bytes, chunk_shift_q);

		// waiver rounded up to whole chunks
		wq     = bc_s1 >> chunk_shift_q;
		wrem   = (wq << chunk_shift_q) != bc_s1;
		wq_up  = {1'b0, wq} + (BCW+1)'(wrem);
		wq_sat = (|wq_up[BCW:CHUNK_WIDTH]) ? CHUNK_MAX : wq_up[CHUNK_WIDTH-1:0];

		nxt_bytes  = held_bytes_q;
		nxt_chunks = held_chunks_q;
		nxt_peak   = peak_q;
		nxt_waiver = waiver_q;
		res_status = cmqt_pkg::ST_OK;
		res_delta  = '0;

		unique case (op_s1)
			cmqt_pkg::OP_RESERVE: begin
				if (track_en_q) begin
					if (rsv_chunks > held_chunks_q) begin
						if (q_fail) begin
							res_status = cmqt_pkg::ST_QUERY_LIMIT;
						end else if (s_fail) begin
							res_status = cmqt_pkg::ST_SEGMENT_QUOTA;
						end else begin
							nxt_bytes  = rsv_bytes;
							nxt_chunks = rsv_chunks;
							if (rsv_chunks > peak_q) begin
								nxt_peak = rsv_chunks;
							end
							// waiver survives only when it was needed
							if (!q_over && !s_over) begin
								nxt_waiver = '0;
							end
							res_delta = DW'(rsv_chunks - held_chunks_q);
						end
					end else begin
						nxt_bytes = rsv_bytes;
					end
				end
			end
			cmqt_pkg::OP_RELEASE: begin
				if (track_en_q) begin
					nxt_bytes = rel_bytes;
					if (rel_chunks < held_chunks_q) begin
						nxt_chunks = rel_chunks;
						res_delta  = DW'(rel_chunks) - DW'(held_chunks_q);
					end
				end
			end
			cmqt_pkg::OP_WAIVER: begin
				if (wq_sat > waiver_q) begin
					nxt_waiver = wq_sat;
				end
			end
			cmqt_pkg::OP_RESET_PEAK: begin
				nxt_peak = held_chunks_q;
			end
			cmqt_pkg::OP_RELEASE_ALL: begin
				res_delta  = '0 - DW'(held_chunks_q);
				nxt_chunks = '0;
				nxt_bytes  = '0;
			end
			default: begin
			end
		endcase

		used_seg  = SW'(seg_s1) + SW'(nxt_chunks);
		res_avail = '0;
		if (track_en_q && (SW'(seg_quota_q) > used_seg)) begin
			res_avail = CW'(SW'(seg_quota_q) - used_seg);
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_en_q    <= 1'b0;
			chunk_shift_q <= cmqt_pkg::CHUNK_SHIFT_RST;
			query_limit_q <= '0;
			seg_quota_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cmqt_pkg::cfg_idx_t'(cfg_index))
				cmqt_pkg::CFG_TRACK_EN:    track_en_q    <= cfg_data[0];
				cmqt_pkg::CFG_CHUNK_SHIFT: chunk_shift_q <= cfg_data[cmqt_pkg::SHIFT_W-1:0];
				cmqt_pkg::CFG_QUERY_LIMIT: query_limit_q <= cfg_data;
				cmqt_pkg::CFG_SEG_QUOTA:   seg_quota_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// tracker state and handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bytes_q  <= '0;
			held_chunks_q <= '0;
			peak_q        <= '0;
			waiver_q      <= '0;
			valid_s1      <= 1'b0;
			m_valid_q     <= 1'b0;
		end else begin
			if (fire) begin
				held_bytes_q  <= nxt_bytes;
				held_chunks_q <= nxt_chunks;
				peak_q        <= nxt_peak;
				waiver_q      <= nxt_waiver;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (fire) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= cmqt_pkg::op_t'(s_tuser);
			bc_s1   <= s_tdata[BCW-1:0];
			enf_s1  <= s_tdata[BCW];
			sess_s1 <= s_tdata[BCW+CW:BCW+1];
			seg_s1  <= s_tdata[BCW+2*CW:BCW+CW+1];
		end
		if (fire) begin
			out_status_q   <= res_status;
			out_delta_q    <= res_delta;
			out_reserved_q <= CW'(nxt_chunks);
			out_peak_q     <= CW'(nxt_peak);
			out_avail_q    <= res_avail;
		end
	end

	`CMQT_ASSERT_IMPL(a_peak_ge_held, 1'b1, held_chunks_q <= peak_q, "held above peak")
	`CMQT_ASSERT_IMPL(a_err_no_delta, m_valid_q && (out_status_q != cmqt_pkg::ST_OK), out_delta_q == '0, "error result carries a chunk delta")
	`CMQT_ASSERT_NEXT(a_err_rollback, fire && (res_status != cmqt_pkg::ST_OK), $stable(held_bytes_q) && $stable(held_chunks_q) && $stable(waiver_q), "failed reserve changed state")

endmodule
